// ===== hw/rtl/go_back_n_sender_window_defines.svh =====
// ----------------------------------------------------------------------------
// Go-Back-N sender window: shared assertion macros
// Concurrent checks sampled on the rising clock, muted while reset is low.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_DEFINES_SVH

// Property that must hold at every edge out of reset
`define GBN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication
`define GBN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define GBN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gbnsw_pkg.sv =====
// ----------------------------------------------------------------------------
// gbnsw_pkg
// Types, codes and constants shared by the Go-Back-N sender window modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbnsw_pkg;

    // Default sizing
    localparam int WINDOW_DEPTH_DEF = 4;
    localparam int SEQ_MODULUS_DEF  = 8;
    localparam int PAYLOAD_BITS_DEF = 64;

    // Fixed field widths on the ports
    localparam int OPCODE_W    = 2;
    localparam int PAYLOAD_W   = 64;
    localparam int FIELD_SEQ_W = 3;
    localparam int KIND_W      = 2;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 72;
    localparam int TUSER_W     = 2;

    // Width for modular sequence arithmetic (sequence space up to 256)
    localparam int CALC_W = 9;

    // Input item opcodes; the fourth code is unused
    typedef enum logic [OPCODE_W-1:0] {
        OP_SEND    = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2
    } t_opcode;

    // Result item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_STATUS = 2'd0,
        KIND_TX     = 2'd1,
        KIND_STOP   = 2'd2,
        KIND_START  = 2'd3
    } t_kind;

    // Source of the sequence field of a result
    typedef enum logic [2:0] {
        SEQ_ZERO = 3'd0,
        SEQ_NEXT = 3'd1,
        SEQ_BASE = 3'd2,
        SEQ_TAG  = 3'd3,
        SEQ_EXP  = 3'd4,
        SEQ_RTX  = 3'd5
    } t_seq_sel;

    // Source of the packet data field of a result
    typedef enum logic [1:0] {
        DATA_ZERO    = 2'd0,
        DATA_PAYLOAD = 2'd1,
        DATA_RAM     = 2'd2
    } t_data_sel;

    // Controller to datapath
    typedef struct packed {
        logic      load;      // capture the input item
        logic      emit;      // load the output register
        logic      commit;    // apply the window update of the item
        logic      rd_issue;  // read the buffered packet at the retransmit slot
        logic      rtx_step;  // advance the retransmit walk
        t_kind     kind;
        t_seq_sel  seq_sel;
        t_data_sel data_sel;
        logic      accepted;
        logic      last;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic                out_free;
        logic [OPCODE_W-1:0] opcode;
        logic                send_ok;
        logic                was_empty;
        logic                ack_valid;
        logic                ack_rest;
        logic                count_zero;
        logic                rtx_last;
    } t_status;

    // Address width of a store of n entries, at least one bit
    function automatic int f_addr_w(input int n);
        int w;
        w = $clog2(n);
        return (w < 1) ? 1 : w;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gbnsw_ram.sv =====
// ----------------------------------------------------------------------------
// gbnsw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbnsw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [gbnsw_pkg::f_addr_w(DEPTH)-1:0]  i_wr_addr,
    input  wire logic [WIDTH-1:0]                       i_wr_data,
    input  wire logic                                   i_rd_en,
    input  wire logic [gbnsw_pkg::f_addr_w(DEPTH)-1:0]  i_rd_addr,
    output logic      [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/gbnsw_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbnsw_ctrl
// Sequencer: takes an item, then steps through its result items one by one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbnsw_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire gbnsw_pkg::t_status i_sts,
    output gbnsw_pkg::t_cmd         o_cmd
);

    import gbnsw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_START_NEW,
        S_START_ACK,
        S_START_TO,
        S_RD,
        S_RTX
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    // Next state and commands
    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                // take an item only at an edge where ready is shown
                if (i_s_axis_tvalid && o_s_axis_tready) begin
                    cmd.load = 1'b1;
                    n_state  = S_FIRST;
                end
            end
            S_FIRST: begin
                if (i_sts.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.commit = 1'b1;
                    cmd.last   = 1'b1;
                    n_state    = S_IDLE;
                    unique case (i_sts.opcode)
                        OP_SEND: begin
                            if (i_sts.send_ok) begin
                                cmd.kind     = KIND_TX;
                                cmd.seq_sel  = SEQ_NEXT;
                                cmd.data_sel = DATA_PAYLOAD;
                                cmd.accepted = 1'b1;
                                cmd.last     = !i_sts.was_empty;
                                n_state      = i_sts.was_empty ? S_START_NEW : S_IDLE;
                            end
                        end
                        OP_ACK: begin
                            if (i_sts.ack_valid) begin
                                cmd.kind    = KIND_STOP;
                                cmd.seq_sel = SEQ_BASE;
                                cmd.last    = !i_sts.ack_rest;
                                n_state     = i_sts.ack_rest ? S_START_ACK : S_IDLE;
                            end
                        end
                        OP_TIMEOUT: begin
                            cmd.kind    = KIND_STOP;
                            cmd.seq_sel = SEQ_EXP;
                            cmd.last    = 1'b0;
                            n_state     = S_START_TO;
                        end
                        default: begin
                            // unused opcode: status item only
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_START_NEW: begin
                if (i_sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.kind     = KIND_START;
                    cmd.seq_sel  = SEQ_TAG;
                    cmd.accepted = 1'b1;
                    cmd.last     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_START_ACK: begin
                if (i_sts.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = KIND_START;
                    cmd.seq_sel = SEQ_BASE;
                    cmd.last    = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_START_TO: begin
                if (i_sts.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = KIND_START;
                    cmd.seq_sel = SEQ_EXP;
                    cmd.last    = i_sts.count_zero;
                    n_state     = i_sts.count_zero ? S_IDLE : S_RD;
                end
            end
            S_RD: begin
                cmd.rd_issue = 1'b1;
                n_state      = S_RTX;
            end
            S_RTX: begin
                if (i_sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.rtx_step = 1'b1;
                    cmd.kind     = KIND_TX;
                    cmd.seq_sel  = SEQ_RTX;
                    cmd.data_sel = DATA_RAM;
                    cmd.last     = i_sts.rtx_last;
                    n_state      = i_sts.rtx_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            o_s_axis_tready <= 1'b0;
        end else begin
            r_state         <= n_state;
            o_s_axis_tready <= (n_state == S_IDLE);
        end
    end

    assign o_cmd = cmd;

endmodule

`default_nettype wire

// ===== hw/rtl/gbnsw_dp.sv =====
// ----------------------------------------------------------------------------
// gbnsw_dp
// Window state, packet buffer, retransmit walk and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "go_back_n_sender_window_defines.svh"

module gbnsw_dp #(
    parameter int WINDOW_DEPTH = gbnsw_pkg::WINDOW_DEPTH_DEF,
    parameter int SEQ_MODULUS  = gbnsw_pkg::SEQ_MODULUS_DEF,
    parameter int PAYLOAD_BITS = gbnsw_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire gbnsw_pkg::t_cmd                      i_cmd,
    output gbnsw_pkg::t_status                        o_sts,
    input  wire logic [gbnsw_pkg::OPCODE_W-1:0]       i_opcode,
    input  wire logic [gbnsw_pkg::PAYLOAD_W-1:0]      i_payload,
    input  wire logic [gbnsw_pkg::FIELD_SEQ_W-1:0]    i_ack_number,
    input  wire logic                                 i_ack_checksum_ok,
    input  wire logic [gbnsw_pkg::FIELD_SEQ_W-1:0]    i_expired_seq,
    input  wire logic                                 i_out_ready,
    output logic                                      o_out_valid,
    output logic [gbnsw_pkg::KIND_W-1:0]              o_kind,
    output logic [gbnsw_pkg::FIELD_SEQ_W-1:0]         o_seq_number,
    output logic [gbnsw_pkg::PAYLOAD_W-1:0]           o_packet_data,
    output logic                                      o_accepted,
    output logic                                      o_window_full,
    output logic                                      o_last
);

    import gbnsw_pkg::*;

    localparam int SEQ_W = f_addr_w(SEQ_MODULUS);
    localparam int IDX_W = f_addr_w(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CALC_W-1:0] MOD_C   = CALC_W'(SEQ_MODULUS);
    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(WINDOW_DEPTH);
    localparam logic [SUM_W-1:0]  DEPTH_S = SUM_W'(WINDOW_DEPTH);

    // Window state
    logic [SEQ_W-1:0] r_base, r_next, r_tag;
    logic [CNT_W-1:0] r_count;
    logic             r_waiting;
    logic [IDX_W-1:0] r_head;

    // Captured input item
    logic [OPCODE_W-1:0]     r_opcode;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [FIELD_SEQ_W-1:0]  r_ack, r_expired;
    logic                    r_ack_ok;

    // Retransmit walk
    logic [IDX_W-1:0] r_rd_slot;
    logic [SEQ_W-1:0] r_rtx_seq;
    logic [CNT_W-1:0] r_rd_left;

    // Output register
    logic                    r_out_valid;
    t_kind                   r_out_kind;
    logic [FIELD_SEQ_W-1:0]  r_out_seq;
    logic [PAYLOAD_W-1:0]    r_out_data;
    logic                    r_out_acc, r_out_full, r_out_last;

    logic [CALC_W-1:0]       ack_c, base_c, count_c, dist_c;
    logic                    ack_valid, send_ok, is_send, is_ack, is_timeout;
    logic [SEQ_W-1:0]        n_base;
    logic [CNT_W-1:0]        n_count_ack;
    logic [IDX_W-1:0]        n_head, send_slot;
    logic                    n_waiting;
    logic                    out_free;
    logic [FIELD_SEQ_W-1:0]  seq_mux;
    logic [PAYLOAD_W-1:0]    data_mux;
    logic [PAYLOAD_BITS-1:0] ram_rd_data;
    logic                    ram_wr_en;

    // Sequence number plus one, wrapped to the sequence space
    function automatic logic [SEQ_W-1:0] f_seq_inc(input logic [SEQ_W-1:0] s);
        logic [CALC_W-1:0] c;
        c = CALC_W'(s) + CALC_W'(1);
        return (c == MOD_C) ? '0 : c[SEQ_W-1:0];
    endfunction

    // Ring index from a sum below twice the depth
    function automatic logic [IDX_W-1:0] f_ring_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] w;
        w = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
        return w[IDX_W-1:0];
    endfunction

    // Low bits of a sequence number as carried on the port
    function automatic logic [FIELD_SEQ_W-1:0] f_seq_out(input logic [SEQ_W-1:0] s);
        logic [CALC_W-1:0] c;
        c = CALC_W'(s);
        return c[FIELD_SEQ_W-1:0];
    endfunction

    // Decode the captured item against the window
    always_comb begin
        is_send    = (r_opcode == OP_SEND);
        is_ack     = (r_opcode == OP_ACK);
        is_timeout = (r_opcode == OP_TIMEOUT);
        ack_c      = CALC_W'(r_ack);
        base_c     = CALC_W'(r_base);
        count_c    = CALC_W'(r_count);
        dist_c     = (ack_c >= base_c) ? (ack_c - base_c) : (ack_c + MOD_C - base_c);
        ack_valid  = r_ack_ok && (ack_c < MOD_C) && (dist_c < count_c);
        send_ok    = (r_count < DEPTH_C);
        n_base     = f_seq_inc(ack_c[SEQ_W-1:0]);
        n_count_ack = CNT_W'(count_c - dist_c - CALC_W'(1));
        n_head     = f_ring_wrap(SUM_W'(r_head) + SUM_W'(dist_c) + SUM_W'(1));
        send_slot  = f_ring_wrap(SUM_W'(r_head) + SUM_W'(r_count));
        // waiting flag after this item
        if (is_send && send_ok) begin
            n_waiting = ((r_count + CNT_W'(1)) == DEPTH_C);
        end else if (is_ack && ack_valid) begin
            n_waiting = 1'b0;
        end else begin
            n_waiting = r_waiting;
        end
    end

    assign out_free  = !r_out_valid || i_out_ready;
    assign ram_wr_en = i_cmd.commit && is_send && send_ok;

    always_comb begin
        o_sts            = '0;
        o_sts.out_free   = out_free;
        o_sts.opcode     = r_opcode;
        o_sts.send_ok    = send_ok;
        o_sts.was_empty  = (r_count == '0);
        o_sts.ack_valid  = ack_valid;
        o_sts.ack_rest   = (count_c != (dist_c + CALC_W'(1)));
        o_sts.count_zero = (r_count == '0);
        o_sts.rtx_last   = (r_rd_left == CNT_W'(1));
    end

    // Capture the input item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opcode <= OP_SEND;
        end else if (i_cmd.load) begin
            r_opcode <= i_opcode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_payload <= i_payload[PAYLOAD_BITS-1:0];
            r_ack     <= i_ack_number;
            r_ack_ok  <= i_ack_checksum_ok;
            r_expired <= i_expired_seq;
        end
    end

    // Window update and retransmit walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= SEQ_W'(1);
            r_next    <= SEQ_W'(1);
            r_count   <= '0;
            r_waiting <= 1'b0;
            r_head    <= '0;
            r_rd_left <= '0;
        end else begin
            if (i_cmd.commit) begin
                r_waiting <= n_waiting;
                if (is_send && send_ok) begin
                    r_next  <= f_seq_inc(r_next);
                    r_count <= r_count + CNT_W'(1);
                end else if (is_ack && ack_valid) begin
                    r_base  <= n_base;
                    r_head  <= n_head;
                    r_count <= n_count_ack;
                end
                if (is_timeout) begin
                    r_rd_left <= r_count;
                end
            end else if (i_cmd.rtx_step) begin
                r_rd_left <= r_rd_left - CNT_W'(1);
            end
        end
    end

    // Tag and walk pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && is_send && send_ok) begin
            r_tag <= r_next;
        end
        if (i_cmd.commit && is_timeout) begin
            r_rd_slot <= r_head;
            r_rtx_seq <= r_base;
        end else if (i_cmd.rtx_step) begin
            r_rd_slot <= f_ring_wrap(SUM_W'(r_rd_slot) + SUM_W'(1));
            r_rtx_seq <= f_seq_inc(r_rtx_seq);
        end
    end

    // Packet buffer
    gbnsw_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (send_slot),
        .i_wr_data (r_payload),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (r_rd_slot),
        .o_rd_data (ram_rd_data)
    );

    // Select result fields
    always_comb begin
        unique case (i_cmd.seq_sel)
            SEQ_ZERO: seq_mux = '0;
            SEQ_NEXT: seq_mux = f_seq_out(r_next);
            SEQ_BASE: seq_mux = f_seq_out(r_base);
            SEQ_TAG:  seq_mux = f_seq_out(r_tag);
            SEQ_EXP:  seq_mux = r_expired;
            SEQ_RTX:  seq_mux = f_seq_out(r_rtx_seq);
            default:  seq_mux = '0;
        endcase
        unique case (i_cmd.data_sel)
            DATA_ZERO:    data_mux = '0;
            DATA_PAYLOAD: data_mux = PAYLOAD_W'(r_payload);
            DATA_RAM:     data_mux = PAYLOAD_W'(ram_rd_data);
            default:      data_mux = '0;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind <= i_cmd.kind;
            r_out_seq  <= seq_mux;
            r_out_data <= data_mux;
            r_out_acc  <= i_cmd.accepted;
            r_out_full <= i_cmd.commit ? n_waiting : r_waiting;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_seq_number  = r_out_seq;
    assign o_packet_data = r_out_data;
    assign o_accepted    = r_out_acc;
    assign o_window_full = r_out_full;
    assign o_last        = r_out_last;

    // Checks
    `GBN_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= DEPTH_C, "window count above depth")
    `GBN_ASSERT(a_full_flag, i_clk, i_rst_n, r_waiting == (r_count == DEPTH_C), "full flag out of step")
    `GBN_ASSERT_IMPL(a_emit_free, i_clk, i_rst_n, i_cmd.emit, out_free, "result loaded over a held item")
    `GBN_ASSERT_IMPL(a_rtx_left, i_clk, i_rst_n, i_cmd.rtx_step, r_rd_left != '0, "retransmit past window")
    `GBN_ASSERT_NEXT(a_rd_then_emit, i_clk, i_rst_n, i_cmd.rd_issue, !i_cmd.rd_issue, "back to back reads")

endmodule

`default_nettype wire

// ===== hw/rtl/go_back_n_sender_window.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Go-Back-N sender window: buffers packets, slides on acknowledgements and
// retransmits the outstanding window on a timer expiry.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis channel: tuser carries the opcode (send,
//   acknowledgement, timer expired), tdata the payload, acknowledgement number,
//   checksum flag and expired timer tag. Result items leave on m_axis: tuser
//   carries the kind (status, transmit, stop timer, start timer), tdata the
//   sequence number, packet data, accepted and window-full flags; tlast marks
//   the final result item of each input item.
//   One item is worked on at a time. After acceptance the item is captured,
//   then its results are registered one by one as the output register frees;
//   each retransmitted packet is first read from the buffer, a registered read.
//   A refused send, a send into a busy window or a bad acknowledgement gives
//   one result, a send into an empty window or a sliding acknowledgement with
//   packets left two, a timeout two plus one per outstanding packet.
//   Reset puts the window at base 1, next sequence 1, empty and not full.
//   The buffer itself is not cleared; only written entries are ever read.
//   A stalled receiver holds the output register; work pauses until it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_sender_window #(
    parameter int WINDOW_DEPTH = gbnsw_pkg::WINDOW_DEPTH_DEF,
    parameter int SEQ_MODULUS  = gbnsw_pkg::SEQ_MODULUS_DEF,
    parameter int PAYLOAD_BITS = gbnsw_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // s_axis tdata: payload[63:0], ack_number[66:64], ack_checksum_ok[67],
    //               expired_seq[70:68], zero pad[71]
    // s_axis tuser: opcode[1:0]
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [gbnsw_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    input  wire logic [gbnsw_pkg::TUSER_W-1:0]     i_s_axis_tuser,
    // m_axis tdata: seq_number[2:0], packet_data[66:3], accepted[67],
    //               window_full[68], zero pad[71:69]
    // m_axis tuser: kind[1:0]
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic [gbnsw_pkg::M_TDATA_W-1:0]        o_m_axis_tdata,
    output logic [gbnsw_pkg::TUSER_W-1:0]          o_m_axis_tuser,
    output logic                                   o_m_axis_tlast
);

    import gbnsw_pkg::*;

    t_cmd    cmd;
    t_status sts;

    logic [KIND_W-1:0]      kind;
    logic [FIELD_SEQ_W-1:0] seq_number;
    logic [PAYLOAD_W-1:0]   packet_data;
    logic                   accepted, window_full;

    // Sequencer
    gbnsw_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    // Window state and result path
    gbnsw_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SEQ_MODULUS  (SEQ_MODULUS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_opcode          (i_s_axis_tuser[OPCODE_W-1:0]),
        .i_payload         (i_s_axis_tdata[63:0]),
        .i_ack_number      (i_s_axis_tdata[66:64]),
        .i_ack_checksum_ok (i_s_axis_tdata[67]),
        .i_expired_seq     (i_s_axis_tdata[70:68]),
        .i_out_ready       (i_m_axis_tready),
        .o_out_valid       (o_m_axis_tvalid),
        .o_kind            (kind),
        .o_seq_number      (seq_number),
        .o_packet_data     (packet_data),
        .o_accepted        (accepted),
        .o_window_full     (window_full),
        .o_last            (o_m_axis_tlast)
    );

    // Pack the result item
    assign o_m_axis_tdata = {3'b000, window_full, accepted, packet_data, seq_number};
    assign o_m_axis_tuser = kind;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: Go-Back-N sender window testbench
// Drives send requests, acknowledgements and timer expiries into the window,
// predicts every result item from a local copy of the window state and checks
// each result field by field. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import gbnsw_pkg::*;

    localparam int DEPTH   = WINDOW_DEPTH_DEF;
    localparam int SEQ_MOD = SEQ_MODULUS_DEF;

    // The fourth opcode is unused by the block; it must answer with a status
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // Sender pacing and run sizing
    localparam int RANDOM_ITEMS = 470;
    localparam int DRAIN_EVERY  = 150;
    localparam int SETTLE_TICKS = 24;

    // One result item as seen on the master side
    typedef struct packed {
        t_kind                  kind;
        logic [FIELD_SEQ_W-1:0] seq;
        logic [PAYLOAD_W-1:0]   data;
        logic                   accepted;
        logic                   full;
        logic                   last;
    } gbn_result_t;

    // Window tracker: predicts result items and checks the ones that arrive
    class gbn_scoreboard;
        gbn_result_t          awaited_results[$];
        gbn_result_t          step_results[$];
        logic [PAYLOAD_W-1:0] ring [DEPTH];
        int                   base;
        int                   next_seq;
        int                   outstanding;
        int                   head;
        bit                   full_flag;
        int                   errors;
        int                   items;
        int                   checked;
        int                   refused;
        int                   slides;
        int                   expiries;
        int                   resent;

        function new();
            base        = 1 % SEQ_MOD;
            next_seq    = 1 % SEQ_MOD;
            outstanding = 0;
            head        = 0;
            full_flag   = 1'b0;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void emit(t_kind kind, int seq, logic [PAYLOAD_W-1:0] data, bit acc);
            gbn_result_t r;
            r.kind     = kind;
            r.seq      = seq[FIELD_SEQ_W-1:0];
            r.data     = data;
            r.accepted = acc;
            r.full     = 1'b0;
            r.last     = 1'b0;
            step_results.insert(step_results.size(), r);
        endfunction

        // Advance the window by one accepted input item and queue its results
        function void take_input(logic [OPCODE_W-1:0] op, logic [PAYLOAD_W-1:0] payload,
                                 logic [FIELD_SEQ_W-1:0] ack, logic ack_ok,
                                 logic [FIELD_SEQ_W-1:0] tag);
            int ack_span;
            int old_base;
            int slot;
            gbn_result_t r;
            items++;
            step_results.delete();
            case (op)
                OP_SEND: begin
                    if (outstanding >= DEPTH) begin
                        refused++;
                        emit(KIND_STATUS, 0, '0, 1'b0);
                    end else begin
                        slot = (head + outstanding) % DEPTH;
                        ring[slot] = payload;
                        emit(KIND_TX, next_seq, payload, 1'b1);
                        if (outstanding == 0)
                            emit(KIND_START, next_seq, '0, 1'b1);
                        next_seq = (next_seq + 1) % SEQ_MOD;
                        outstanding++;
                        full_flag = (outstanding >= DEPTH);
                    end
                end
                OP_ACK: begin
                    ack_span = (int'(ack) + SEQ_MOD - base) % SEQ_MOD;
                    if (ack_ok && int'(ack) < SEQ_MOD && ack_span < outstanding) begin
                        slides++;
                        old_base    = base;
                        full_flag   = 1'b0;
                        base        = (int'(ack) + 1) % SEQ_MOD;
                        head        = (head + ack_span + 1) % DEPTH;
                        outstanding = outstanding - (ack_span + 1);
                        emit(KIND_STOP, old_base, '0, 1'b0);
                        if (outstanding != 0)
                            emit(KIND_START, base, '0, 1'b0);
                    end else begin
                        emit(KIND_STATUS, 0, '0, 1'b0);
                    end
                end
                OP_TIMEOUT: begin
                    expiries++;
                    emit(KIND_STOP, tag, '0, 1'b0);
                    emit(KIND_START, tag, '0, 1'b0);
                    for (int i = 0; i < outstanding; i++) begin
                        resent++;
                        emit(KIND_TX, (base + i) % SEQ_MOD, ring[(head + i) % DEPTH], 1'b0);
                    end
                end
                default: begin
                    emit(KIND_STATUS, 0, '0, 1'b0);
                end
            endcase
            // Stamp the window-full flag on every result and mark the final one
            for (int i = 0; i < step_results.size(); i++) begin
                r      = step_results[i];
                r.full = full_flag;
                r.last = (i == step_results.size() - 1);
                awaited_results.insert(awaited_results.size(), r);
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("tb: mismatch at %0t ns: %s", $realtime, what);
        endtask

        // Compare one result item against the oldest awaited one
        task check_result(gbn_result_t got);
            gbn_result_t want;
            checked++;
            if (awaited_results.size() == 0) begin
                report($sformatf("result with nothing awaited: kind %s seq %0d",
                                 got.kind.name(), got.seq));
            end else begin
                want = awaited_results.pop_front();
                if (got.kind !== want.kind)
                    report($sformatf("kind %s, want %s", got.kind.name(), want.kind.name()));
                if (got.seq !== want.seq)
                    report($sformatf("seq %0d, want %0d", got.seq, want.seq));
                if (got.data !== want.data)
                    report($sformatf("data %h, want %h", got.data, want.data));
                if (got.accepted !== want.accepted)
                    report($sformatf("accepted %b, want %b", got.accepted, want.accepted));
                if (got.full !== want.full)
                    report($sformatf("window_full %b, want %b", got.full, want.full));
                if (got.last !== want.last)
                    report($sformatf("last %b, want %b", got.last, want.last));
            end
        endtask
    endclass

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;  // payload, ack_number, ack_checksum_ok, expired_seq
    logic [TUSER_W-1:0]     s_tuser  = '0;  // opcode
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;        // seq_number, packet_data, accepted, window_full
    logic [TUSER_W-1:0]     m_tuser;        // kind
    logic                   m_tlast;

    gbn_scoreboard sb;
    int            burst_left = 0;
    int            rx_left    = 0;
    int            rx_mode    = 0;
    int unsigned   rx_tick    = 0;

    go_back_n_sender_window u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stall the result side: each stretch picks a mode for a random number of cycles
    always @(posedge clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(16, 96);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rx_tick[2:0] < 3'd5);
        endcase
    end

    // Check every result item taken on the master side
    always @(posedge clk) begin
        gbn_result_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.kind     = t_kind'(m_tuser);
            got.seq      = m_tdata[2:0];
            got.data     = m_tdata[66:3];
            got.accepted = m_tdata[67];
            got.full     = m_tdata[68];
            got.last     = m_tlast;
            sb.check_result(got);
        end
    end

    // Offer one input item and hold it until the block takes it
    task automatic offer_item(input logic [OPCODE_W-1:0] op, input logic [PAYLOAD_W-1:0] payload,
                              input logic [FIELD_SEQ_W-1:0] ack, input logic ack_ok,
                              input logic [FIELD_SEQ_W-1:0] tag);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, tag, ack_ok, ack, payload};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.take_input(op, payload, ack, ack_ok, tag);
    endtask

    // End a burst now and then with a random gap
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 12);
        end
    endtask

    // Hold off the sender until every awaited result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [PAYLOAD_W-1:0] pick_payload();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly well-formed traffic: sends, in-window acks, expiries on the base tag
    task automatic random_item();
        int                     r;
        logic [OPCODE_W-1:0]    op;
        logic [FIELD_SEQ_W-1:0] ack;
        logic [FIELD_SEQ_W-1:0] tag;
        logic                   ok;
        r   = $urandom_range(0, 99);
        ack = FIELD_SEQ_W'($urandom);
        tag = FIELD_SEQ_W'($urandom);
        ok  = 1'b1;
        if (r < 45) begin
            op = OP_SEND;
        end else if (r < 80) begin
            op = OP_ACK;
            if (sb.outstanding > 0 && r < 76)
                ack = FIELD_SEQ_W'((sb.base + $urandom_range(0, sb.outstanding - 1)) % SEQ_MOD);
            else
                ok = 1'($urandom);
        end else if (r < 92) begin
            op = OP_TIMEOUT;
            if (r < 89)
                tag = FIELD_SEQ_W'(sb.base);
        end else if (r < 96) begin
            op = OP_UNUSED;
        end else begin
            op = OP_ACK;
            ok = 1'b0;
        end
        offer_item(op, pick_payload(), ack, ok, tag);
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty window: expiry, stray ack and the unused opcode
        offer_item(OP_TIMEOUT, '1, 3'd7, 1'b1, 3'd0);
        offer_item(OP_ACK, '0, 3'd1, 1'b1, 3'd7);
        offer_item(OP_UNUSED, '1, 3'd7, 1'b1, 3'd7);
        // Fill the window with extreme payloads, then overflow it
        offer_item(OP_SEND, '0, 3'd0, 1'b0, 3'd0);
        offer_item(OP_SEND, '1, 3'd7, 1'b1, 3'd7);
        offer_item(OP_SEND, 64'hA5A5_A5A5_A5A5_A5A5, 3'd2, 1'b0, 3'd5);
        offer_item(OP_SEND, 64'h5A5A_5A5A_5A5A_5A5A, 3'd5, 1'b1, 3'd2);
        offer_item(OP_SEND, 64'h8000_0000_0000_0001, 3'd1, 1'b1, 3'd1);
        // Bad checksum and acks outside the window
        offer_item(OP_ACK, '1, 3'd2, 1'b0, 3'd0);
        offer_item(OP_ACK, '0, 3'd6, 1'b1, 3'd0);
        offer_item(OP_ACK, '0, 3'd0, 1'b1, 3'd0);
        // Retransmit a full window, slide partly, refill and slide to empty
        offer_item(OP_TIMEOUT, '0, 3'd0, 1'b0, 3'd7);
        offer_item(OP_ACK, '0, 3'd2, 1'b1, 3'd0);
        offer_item(OP_SEND, 64'h0123_4567_89AB_CDEF, 3'd0, 1'b0, 3'd0);
        offer_item(OP_SEND, 64'hFEDC_BA98_7654_3210, 3'd0, 1'b0, 3'd0);
        offer_item(OP_SEND, 64'h1, 3'd0, 1'b0, 3'd0);
        offer_item(OP_ACK, '0, 3'd6, 1'b1, 3'd0);
        // Wrap the sequence space and retransmit across the wrap
        offer_item(OP_SEND, 64'h7FFF_FFFF_FFFF_FFFF, 3'd0, 1'b0, 3'd0);
        offer_item(OP_SEND, 64'h0000_0001_0000_0000, 3'd0, 1'b0, 3'd0);
        offer_item(OP_SEND, 64'hDEAD_BEEF_0BAD_F00D, 3'd0, 1'b0, 3'd0);
        offer_item(OP_TIMEOUT, '0, 3'd0, 1'b0, 3'd5);
        offer_item(OP_ACK, '0, 3'd0, 1'b1, 3'd0);
        offer_item(OP_ACK, '0, 3'd1, 1'b1, 3'd0);
        drain_results();

        // Random traffic with bursty sender and periodic full drains
        burst_left = 0;
        for (int k = 1; k <= RANDOM_ITEMS; k++) begin
            random_item();
            pace_sender();
            if (k % DRAIN_EVERY == 0)
                drain_results();
        end

        drain_results();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));

        $display("tb: %0d items in: %0d refused sends, %0d window slides, %0d timer expiries",
                 sb.items, sb.refused, sb.slides, sb.expiries);
        $display("tb: %0d results checked, %0d packets resent, %0d mismatches",
                 sb.checked, sb.resent, sb.errors);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog: end a hung run
    initial begin
        #800_000;
        $display("tb: watchdog expired with %0d results still awaited", sb.pending());
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== go_back_n_sender_window.f =====
+incdir+hw/rtl
hw/rtl/gbnsw_pkg.sv
hw/rtl/gbnsw_ram.sv
hw/rtl/gbnsw_ctrl.sv
hw/rtl/gbnsw_dp.sv
hw/rtl/go_back_n_sender_window.sv
verif/tb.sv
